>>> design/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg: shared types and microcode for the pixel centroid tracker
// Control word layout, the step addresses of the program and the fixed
// formats of the registers and the level field.
// ----------------------------------------------------------------------------
package pct_pkg;

  // fixed formats
  localparam int unsigned THRESH_BITS = 13;
  localparam int unsigned Q16_BITS    = 17;
  localparam int unsigned LEVEL_BITS  = 16;
  localparam int unsigned LEVEL_FRAC  = 8;
  localparam int unsigned INTEN_BITS  = 8;
  localparam int unsigned RCNT_BITS   = 16;
  localparam int unsigned MCNT_BITS   = 8;
  localparam int unsigned STEP_BITS   = 4;

  localparam logic [Q16_BITS-1:0]    ONE_Q16       = 17'h10000;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET  = 13'd16;

  // register indexes on the configuration port
  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_ALPHA  = 1'b1;

  // input command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_SEED   = 1'b1;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_W,
    MUL_X,
    MUL_Y,
    MUL_L
  } mul_e;

  // product writeback target
  typedef enum logic [2:0] {
    WB_NONE,
    WB_W,
    WB_X,
    WB_Y,
    WB_L
  } wb_e;

  // sequencing operation
  typedef enum logic [1:0] {
    SEQ_NEXT,   // go to the following step
    SEQ_FETCH,  // hold until a request is taken
    SEQ_TEST,   // jump to target on seed or rejected update
    SEQ_EMIT    // hold until the result register is free, then jump
  } seq_e;

  typedef struct packed {
    mul_e                 mul;
    wb_e                  wb;
    logic                 chk;
    logic                 bump;
    seq_e                 seq;
    logic [STEP_BITS-1:0] tgt;
  } ucode_t;

  // step addresses
  localparam logic [STEP_BITS-1:0] STEP_WAIT  = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_CHECK = 4'd1;
  localparam logic [STEP_BITS-1:0] STEP_MW    = 4'd2;
  localparam logic [STEP_BITS-1:0] STEP_WW    = 4'd3;
  localparam logic [STEP_BITS-1:0] STEP_MX    = 4'd4;
  localparam logic [STEP_BITS-1:0] STEP_MY    = 4'd5;
  localparam logic [STEP_BITS-1:0] STEP_ML    = 4'd6;
  localparam logic [STEP_BITS-1:0] STEP_WL    = 4'd7;
  localparam logic [STEP_BITS-1:0] STEP_EMIT  = 4'd8;

  // the program
  function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
    ucode_t w;
    w = '{mul: MUL_NONE, wb: WB_NONE, chk: 1'b0, bump: 1'b0,
          seq: SEQ_NEXT, tgt: STEP_WAIT};
    case (step)
      STEP_WAIT:  w.seq = SEQ_FETCH;
      STEP_CHECK: begin
        w.chk = 1'b1;
        w.seq = SEQ_TEST;
        w.tgt = STEP_EMIT;
      end
      STEP_MW:    w.mul = MUL_W;
      STEP_WW:    w.wb  = WB_W;
      STEP_MX:    w.mul = MUL_X;
      STEP_MY: begin
        w.mul = MUL_Y;
        w.wb  = WB_X;
      end
      STEP_ML: begin
        w.mul = MUL_L;
        w.wb  = WB_Y;
      end
      STEP_WL: begin
        w.wb   = WB_L;
        w.bump = 1'b1;
      end
      STEP_EMIT: begin
        w.seq = SEQ_EMIT;
        w.tgt = STEP_WAIT;
      end
      default: begin
        w.seq = SEQ_EMIT;
        w.tgt = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

>>> design/pct_in_if.sv
// ----------------------------------------------------------------------------
// pct_in_if: pixel request channel
// Valid/ready channel carrying one pixel and its command.
// ----------------------------------------------------------------------------
interface pct_in_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [7:0]            intensity;

  modport source (output valid, cmd, pixel_x, pixel_y, intensity, input ready);
  modport sink   (input valid, cmd, pixel_x, pixel_y, intensity, output ready);
endinterface

>>> design/pct_out_if.sv
// ----------------------------------------------------------------------------
// pct_out_if: centroid result channel
// Valid/ready channel carrying the centroid after each request.
// ----------------------------------------------------------------------------
interface pct_out_if #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8
);
  logic                            valid;
  logic                            ready;
  logic                            accepted;
  logic [COORD_BITS+FRAC_BITS-1:0] centroid_x;
  logic [COORD_BITS+FRAC_BITS-1:0] centroid_y;
  logic [15:0]                     centroid_level;
  logic [15:0]                     region_count;
  logic [7:0]                      merged_count;

  modport source (output valid, accepted, centroid_x, centroid_y, centroid_level,
                  region_count, merged_count, input ready);
  modport sink   (input valid, accepted, centroid_x, centroid_y, centroid_level,
                  region_count, merged_count, output ready);
endinterface

>>> design/pixel_centroid_tracker.sv
// ----------------------------------------------------------------------------
// pixel_centroid_tracker: single bright-spot centroid follower
// Microcoded sequencer over one multiplier pair that seeds, gates and blends
// the centroid position and level.
// ----------------------------------------------------------------------------
// One request is processed at a time. A seed or a rejected update passes
// through the fetch, check and result steps; a merged update runs the blend
// program between check and result, which does the weight decay and then the
// x, y and level blends one after the other through a single pair of
// 17 x max(COORD_BITS+FRAC_BITS, 16) multipliers.
// The result sits in an output register, so the next request is taken while
// it waits; the sequencer only stalls at its result step if the previous
// result has still not been taken. There is no clearing pass after reset.
// Registers: distance_threshold at byte 0, alpha at byte 4 (Q1.16, values
// above 1.0 act as 1.0).
module pixel_centroid_tracker
  import pct_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  pct_in_if.sink      in_if,
  pct_out_if.source   out_if
);

  localparam int unsigned POS_BITS  = COORD_BITS + FRAC_BITS;
  localparam int unsigned DW        = (POS_BITS > LEVEL_BITS) ? POS_BITS : LEVEL_BITS;
  localparam int unsigned PW        = Q16_BITS + DW;
  localparam int unsigned DIST_BITS = POS_BITS + 1;
  localparam int unsigned LIM_BITS  = THRESH_BITS + FRAC_BITS;
  localparam int unsigned CW        = (DIST_BITS > LIM_BITS) ? DIST_BITS : LIM_BITS;

  // configuration
  logic [THRESH_BITS-1:0] thresh_q;
  logic [Q16_BITS-1:0]    alpha_q;
  logic                   cfg_wr;

  // centroid state
  logic [POS_BITS-1:0]   pos_x_q, pos_x_d;
  logic [POS_BITS-1:0]   pos_y_q, pos_y_d;
  logic [LEVEL_BITS-1:0] level_q, level_d;
  logic [Q16_BITS-1:0]   weight_q, weight_d;
  logic [RCNT_BITS-1:0]  region_q, region_d;
  logic [MCNT_BITS-1:0]  total_q, total_d;
  logic                  acc_q, acc_d;

  // sequencer
  logic [STEP_BITS-1:0] step_q, step_d;
  ucode_t               uc;

  // captured request
  logic                  cmd_q;
  logic [POS_BITS-1:0]   px_q, py_q;
  logic [LEVEL_BITS-1:0] lv_q;

  // datapath
  logic [Q16_BITS-1:0] alpha_sat, op_g, op_gn;
  logic [DW-1:0]       op_old, op_new;
  logic [PW-1:0]       prod_old_q, prod_new_q, prod_sum;
  logic [POS_BITS-1:0] dx, dy;
  logic [CW-1:0]       man_dist, limit;
  logic                take, pass, out_free;

  // result register
  logic                  out_valid_q;
  logic                  out_acc_q;
  logic [POS_BITS-1:0]   out_x_q, out_y_q;
  logic [LEVEL_BITS-1:0] out_lv_q;
  logic [RCNT_BITS-1:0]  out_rc_q;
  logic [MCNT_BITS-1:0]  out_mc_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_ALPHA) ? 32'(alpha_q) : 32'(thresh_q);

  assign uc        = ucode_rom(step_q);
  assign in_if.ready = (step_q == STEP_WAIT);
  assign take      = in_if.valid && in_if.ready;
  assign out_free  = !out_valid_q || out_if.ready;
  assign alpha_sat = alpha_q[Q16_BITS-1] ? ONE_Q16 : alpha_q;

  // gate: Manhattan distance against the threshold in position format
  assign dx       = (pos_x_q >= px_q) ? (pos_x_q - px_q) : (px_q - pos_x_q);
  assign dy       = (pos_y_q >= py_q) ? (pos_y_q - py_q) : (py_q - pos_y_q);
  assign man_dist = CW'(dx) + CW'(dy);
  assign limit    = CW'({thresh_q, {FRAC_BITS{1'b0}}});
  assign pass     = (cmd_q == CMD_SEED) || (man_dist < limit);

  // multiplier operand selection
  always_comb begin
    op_g   = weight_q;
    op_gn  = ONE_Q16 - weight_q;
    op_old = '0;
    op_new = '0;
    case (uc.mul)
      MUL_W: begin
        op_old = DW'(alpha_sat);
        op_gn  = '0;
      end
      MUL_X: begin
        op_old = DW'(pos_x_q);
        op_new = DW'(px_q);
      end
      MUL_Y: begin
        op_old = DW'(pos_y_q);
        op_new = DW'(py_q);
      end
      MUL_L: begin
        op_old = DW'(level_q);
        op_new = DW'(lv_q);
      end
      default: begin
        op_g  = '0;
        op_gn = '0;
      end
    endcase
  end

  assign prod_sum = prod_old_q + prod_new_q;

  // state update: seed in the check step, blend writebacks, counters
  always_comb begin
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    level_d  = level_q;
    weight_d = weight_q;
    region_d = region_q;
    total_d  = total_q;
    acc_d    = acc_q;
    if (uc.chk) begin
      acc_d = pass;
      if (cmd_q == CMD_SEED) begin
        pos_x_d  = px_q;
        pos_y_d  = py_q;
        level_d  = lv_q;
        region_d = RCNT_BITS'(1);
      end
    end
    case (uc.wb)
      WB_W:    weight_d = prod_sum[16 +: Q16_BITS];
      WB_X:    pos_x_d  = prod_sum[16 +: POS_BITS];
      WB_Y:    pos_y_d  = prod_sum[16 +: POS_BITS];
      WB_L:    level_d  = prod_sum[16 +: LEVEL_BITS];
      default: ;
    endcase
    if (uc.bump) begin
      if (region_q != {RCNT_BITS{1'b1}}) region_d = region_q + RCNT_BITS'(1);
      total_d = total_q + MCNT_BITS'(1);
    end
  end

  // next step
  always_comb begin
    step_d = step_q + STEP_BITS'(1);
    case (uc.seq)
      SEQ_FETCH: if (!take) step_d = step_q;
      SEQ_TEST:  if (cmd_q == CMD_SEED || !pass) step_d = uc.tgt;
      SEQ_EMIT:  step_d = out_free ? uc.tgt : step_q;
      default:   ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= THRESH_RESET;
      alpha_q     <= ONE_Q16;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      level_q     <= '0;
      weight_q    <= ONE_Q16;
      region_q    <= '0;
      total_q     <= '0;
      acc_q       <= 1'b0;
      step_q      <= STEP_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_ALPHA) alpha_q <= pwdata[Q16_BITS-1:0];
        else                       thresh_q <= pwdata[THRESH_BITS-1:0];
      end
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      level_q  <= level_d;
      weight_q <= weight_d;
      region_q <= region_d;
      total_q  <= total_d;
      acc_q    <= acc_d;
      step_q   <= step_d;
      if (uc.seq == SEQ_EMIT && out_free) out_valid_q <= 1'b1;
      else if (out_if.ready)              out_valid_q <= 1'b0;
    end
  end

  // payload registers: captured request, products, result
  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= in_if.cmd;
      px_q  <= {in_if.pixel_x, {FRAC_BITS{1'b0}}};
      py_q  <= {in_if.pixel_y, {FRAC_BITS{1'b0}}};
      lv_q  <= {in_if.intensity, {LEVEL_FRAC{1'b0}}};
    end
    prod_old_q <= PW'(op_g) * PW'(op_old);
    prod_new_q <= PW'(op_gn) * PW'(op_new);
    if (uc.seq == SEQ_EMIT && out_free) begin
      out_acc_q <= acc_q;
      out_x_q   <= pos_x_q;
      out_y_q   <= pos_y_q;
      out_lv_q  <= level_q;
      out_rc_q  <= region_q;
      out_mc_q  <= total_q;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.accepted       = out_acc_q;
  assign out_if.centroid_x     = out_x_q;
  assign out_if.centroid_y     = out_y_q;
  assign out_if.centroid_level = out_lv_q;
  assign out_if.region_count   = out_rc_q;
  assign out_if.merged_count   = out_mc_q;

endmodule
